// ===== sv/pfsb_pkg.sv =====
// shared types, constants and codes for the paired fifo spill balance unit
`timescale 1ns / 1ps
`default_nettype none

package pfsb_pkg;

    // default queue depth
    localparam int unsigned DEPTH_DEF = 16;

    // configuration port widths
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;

    // configuration reset values
    localparam logic       PAIR_BOUND_RST   = 1'b0;
    localparam logic [3:0] OVF_LIMIT_RST    = 4'd10;
    localparam logic [4:0] ACCEPT_BELOW_RST = 5'd9;
    localparam logic [3:0] REFILL_ABOVE_RST = 4'd1;

    // command codes
    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_QRY = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAIR_BOUND   = 2'd0,
        REG_OVF_LIMIT    = 2'd1,
        REG_ACCEPT_BELOW = 2'd2,
        REG_REFILL_ABOVE = 2'd3
    } t_reg_idx;

    // configuration as seen by the control logic
    typedef struct packed {
        logic       pair_bound;
        logic [3:0] overflow_limit;
        logic [4:0] partner_accept_below;
        logic [3:0] partner_refill_above;
    } t_cfg;

    // input beat
    typedef struct packed {
        logic [1:0]          cmd;
        logic                queue_sel;
        logic signed [31:0]  push_value;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic signed [31:0]  result_value;
        logic                was_empty;
        logic                single_overflow;
        logic                pair_overflow;
        logic                pair_empty;
        logic                dropped_full;
        logic [4:0]          count_a;
        logic [4:0]          count_b;
    } t_out_item;

endpackage

`default_nettype wire

// ===== sv/pfsb_mem.sv =====
// single-port-write, single-port-read queue store with registered read data
`timescale 1ns / 1ps
`default_nettype none

module pfsb_mem #(
    parameter int unsigned DEPTH = pfsb_pkg::DEPTH_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/pfsb_ctrl.sv =====
// queue pointers, counts, spill/refill decisions, sequencing and output register
`timescale 1ns / 1ps
`default_nettype none

module pfsb_ctrl #(
    parameter int unsigned DEPTH = pfsb_pkg::DEPTH_DEF,
    localparam int unsigned AW   = $clog2(DEPTH),
    localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire pfsb_pkg::t_cfg      i_cfg,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire pfsb_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output pfsb_pkg::t_out_item      o_out_data,
    output logic                     o_a_we,
    output logic [AW-1:0]            o_a_waddr,
    output logic [31:0]              o_a_wdata,
    output logic                     o_a_re,
    output logic [AW-1:0]            o_a_raddr,
    input  wire logic [31:0]         i_a_rdata,
    output logic                     o_b_we,
    output logic [AW-1:0]            o_b_waddr,
    output logic [31:0]              o_b_wdata,
    output logic                     o_b_re,
    output logic [AW-1:0]            o_b_raddr,
    input  wire logic [31:0]         i_b_rdata
);

    localparam int unsigned CMPW = (CW > 5) ? CW : 5;
    localparam int unsigned SW   = CW + 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RESP = 2'b10
    } t_state;

    t_state r_state;
    logic [AW-1:0] r_rd_a, r_wr_a, r_rd_b, r_wr_b;
    logic [AW-1:0] n_rd_a, n_wr_a, n_rd_b, n_wr_b;
    logic [CW-1:0] r_fill_a, r_fill_b;
    logic [CW-1:0] n_fill_a, n_fill_b;

    // pending item between accept and response
    pfsb_pkg::t_out_item r_item;
    pfsb_pkg::t_out_item n_item;
    logic          r_res_use, r_res_b;
    logic          r_xfer, r_xfer_to_b;
    logic [AW-1:0] r_xfer_addr;
    logic          r_xfer_fwd;
    logic [31:0]   r_xfer_val;
    logic          n_xfer;
    logic [AW-1:0] n_xfer_addr;
    logic          n_xfer_fwd;
    logic          n_res_use;

    logic                r_out_valid;
    pfsb_pkg::t_out_item r_out_data;
    pfsb_pkg::t_out_item w_resp;

    logic w_acc, w_resp_go, w_sel, w_enq_ok;

    // per-queue view: me is the selected queue, mate the other
    logic [CW-1:0] w_me_fill, w_mate_fill, w_me_fill_n, w_mate_fill_n;
    logic [AW-1:0] w_me_rd, w_me_wr, w_mate_rd, w_mate_wr;
    logic [AW-1:0] w_me_rd_n, w_me_wr_n, w_mate_rd_n, w_mate_wr_n;
    logic          w_me_re, w_mate_re, w_me_we;
    logic          w_empty, w_sov, w_pov, w_pem, w_drop;
    logic [SW-1:0] w_sum;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        f_next = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_resp_go  = (r_state == ST_RESP) && (!r_out_valid || i_out_ready);
    assign w_sel      = i_in_data.queue_sel;

    assign w_me_fill   = w_sel ? r_fill_b : r_fill_a;
    assign w_mate_fill = w_sel ? r_fill_a : r_fill_b;
    assign w_me_rd     = w_sel ? r_rd_b : r_rd_a;
    assign w_me_wr     = w_sel ? r_wr_b : r_wr_a;
    assign w_mate_rd   = w_sel ? r_rd_a : r_rd_b;
    assign w_mate_wr   = w_sel ? r_wr_a : r_wr_b;

    // command decode and spill/refill decisions
    always_comb begin
        w_me_fill_n   = w_me_fill;
        w_mate_fill_n = w_mate_fill;
        w_me_rd_n     = w_me_rd;
        w_me_wr_n     = w_me_wr;
        w_mate_rd_n   = w_mate_rd;
        w_mate_wr_n   = w_mate_wr;
        w_me_re       = 1'b0;
        w_mate_re     = 1'b0;
        w_me_we       = 1'b0;
        w_empty       = 1'b0;
        w_sov         = 1'b0;
        w_pov         = 1'b0;
        w_pem         = 1'b0;
        w_drop        = 1'b0;
        n_xfer        = 1'b0;
        n_xfer_addr   = w_mate_wr;
        n_xfer_fwd    = 1'b0;
        n_res_use     = 1'b0;
        case (i_in_data.cmd)
            pfsb_pkg::CMD_ENQ: begin
                if (w_me_fill == CW'(DEPTH)) begin
                    w_drop = 1'b1;
                end else begin
                    w_me_we     = 1'b1;
                    w_me_wr_n   = f_next(w_me_wr);
                    w_me_fill_n = w_me_fill + CW'(1);
                    if (CMPW'(w_me_fill_n) > CMPW'(i_cfg.overflow_limit)) begin
                        w_sov = 1'b1;
                        if (i_cfg.pair_bound) begin
                            if (CMPW'(w_mate_fill) < CMPW'(i_cfg.partner_accept_below) &&
                                w_mate_fill != CW'(DEPTH)) begin
                                // spill: head of me moves to the tail of mate
                                w_me_re       = 1'b1;
                                w_me_rd_n     = f_next(w_me_rd);
                                w_me_fill_n   = w_me_fill;
                                n_xfer        = 1'b1;
                                n_xfer_addr   = w_mate_wr;
                                // an empty queue's head is the value written this cycle
                                n_xfer_fwd    = (w_me_fill == '0);
                                w_mate_wr_n   = f_next(w_mate_wr);
                                w_mate_fill_n = w_mate_fill + CW'(1);
                            end else begin
                                w_pov = 1'b1;
                            end
                        end
                    end
                end
            end
            pfsb_pkg::CMD_DEQ: begin
                if (w_me_fill == '0) begin
                    w_empty = 1'b1;
                end else begin
                    w_me_re     = 1'b1;
                    n_res_use   = 1'b1;
                    w_me_rd_n   = f_next(w_me_rd);
                    w_me_fill_n = w_me_fill - CW'(1);
                    if (w_me_fill_n == '0 && i_cfg.pair_bound) begin
                        if (CMPW'(w_mate_fill) > CMPW'(i_cfg.partner_refill_above)) begin
                            // refill: head of mate moves into the emptied queue
                            w_mate_re     = 1'b1;
                            w_mate_rd_n   = f_next(w_mate_rd);
                            w_mate_fill_n = w_mate_fill - CW'(1);
                            n_xfer        = 1'b1;
                            n_xfer_addr   = w_me_wr;
                            w_me_wr_n     = f_next(w_me_wr);
                            w_me_fill_n   = CW'(1);
                        end else begin
                            w_pem = 1'b1;
                        end
                    end
                end
            end
            pfsb_pkg::CMD_QRY: begin
                if (w_me_fill == '0) begin
                    w_empty = 1'b1;
                end else begin
                    w_me_re   = 1'b1;
                    n_res_use = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // map me/mate back onto the a/b queues
    always_comb begin
        n_rd_a   = w_sel ? w_mate_rd_n   : w_me_rd_n;
        n_wr_a   = w_sel ? w_mate_wr_n   : w_me_wr_n;
        n_fill_a = w_sel ? w_mate_fill_n : w_me_fill_n;
        n_rd_b   = w_sel ? w_me_rd_n     : w_mate_rd_n;
        n_wr_b   = w_sel ? w_me_wr_n     : w_mate_wr_n;
        n_fill_b = w_sel ? w_me_fill_n   : w_mate_fill_n;

        n_item                 = '0;
        n_item.was_empty       = w_empty;
        n_item.single_overflow = w_sov;
        n_item.pair_overflow   = w_pov;
        n_item.pair_empty      = w_pem;
        n_item.dropped_full    = w_drop;
        n_item.count_a         = 5'(n_fill_a);
        n_item.count_b         = 5'(n_fill_b);
    end

    assign w_enq_ok = w_acc && (i_in_data.cmd == pfsb_pkg::CMD_ENQ) && !w_drop;

    // memory ports: reads and enqueue write at accept, transfer write at response
    assign o_a_re    = w_acc && (w_sel ? w_mate_re : w_me_re);
    assign o_b_re    = w_acc && (w_sel ? w_me_re : w_mate_re);
    assign o_a_raddr = r_rd_a;
    assign o_b_raddr = r_rd_b;

    always_comb begin
        o_a_we    = 1'b0;
        o_a_waddr = r_wr_a;
        o_a_wdata = i_in_data.push_value;
        o_b_we    = 1'b0;
        o_b_waddr = r_wr_b;
        o_b_wdata = i_in_data.push_value;
        if (r_state == ST_RESP) begin
            o_a_we    = w_resp_go && r_xfer && !r_xfer_to_b;
            o_a_waddr = r_xfer_addr;
            o_a_wdata = r_xfer_fwd ? r_xfer_val : i_b_rdata;
            o_b_we    = w_resp_go && r_xfer && r_xfer_to_b;
            o_b_waddr = r_xfer_addr;
            o_b_wdata = r_xfer_fwd ? r_xfer_val : i_a_rdata;
        end else begin
            o_a_we = w_acc && w_me_we && !w_sel;
            o_b_we = w_acc && w_me_we && w_sel;
        end
    end

    // response beat built from the pending item and the read data
    always_comb begin
        w_resp = r_item;
        if (r_res_use) begin
            w_resp.result_value = $signed(r_res_b ? i_b_rdata : i_a_rdata);
        end
    end

    // sequencer, pointers and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_a   <= '0;
            r_wr_a   <= '0;
            r_rd_b   <= '0;
            r_wr_b   <= '0;
            r_fill_a <= '0;
            r_fill_b <= '0;
            r_xfer   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_state  <= ST_RESP;
                        r_rd_a   <= n_rd_a;
                        r_wr_a   <= n_wr_a;
                        r_rd_b   <= n_rd_b;
                        r_wr_b   <= n_wr_b;
                        r_fill_a <= n_fill_a;
                        r_fill_b <= n_fill_b;
                        r_xfer   <= n_xfer;
                    end
                end
                ST_RESP: begin
                    if (w_resp_go) begin
                        r_state <= ST_IDLE;
                        r_xfer  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // pending item payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item      <= n_item;
            r_res_use   <= n_res_use;
            r_res_b     <= w_sel;
            r_xfer_to_b <= (i_in_data.cmd == pfsb_pkg::CMD_ENQ) ? !w_sel : w_sel;
            r_xfer_addr <= n_xfer_addr;
            r_xfer_fwd  <= n_xfer_fwd;
            r_xfer_val  <= i_in_data.push_value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_resp_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_resp_go) begin
            r_out_data <= w_resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_sum = SW'(r_fill_a) + SW'(r_fill_b);

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_a <= CW'(DEPTH)) && (r_fill_b <= CW'(DEPTH)))
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill_a == '0) |-> (r_rd_a == r_wr_a))
        else $error("queue a empty with pointers apart");

    a_acc_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state == ST_RESP))
        else $error("accepted beat did not enter response");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP) |-> !(o_a_we && o_b_we))
        else $error("transfer wrote both stores");

    a_enq_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_enq_ok |=> (w_sum == $past(w_sum) + SW'(1)))
        else $error("enqueue did not add exactly one item");

endmodule

`default_nettype wire

// ===== sv/paired_fifo_spill_balance_unit.sv =====
// Sequence: an accepted beat moves the sequencer to its response state, and the result beat is
//   registered into the output register once that is free; no new beat is accepted until then, as
//   the store read must return before a spill or refill writes the moved item into the other store.
// Reset: pointers, counts, sequencer and output valid clear; registers take their
//   default values; the stores are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module paired_fifo_spill_balance_unit #(
    parameter int unsigned DEPTH = pfsb_pkg::DEPTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire pfsb_pkg::t_in_item                  i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output pfsb_pkg::t_out_item                      o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pfsb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pfsb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned AW = $clog2(DEPTH);

    pfsb_pkg::t_cfg r_cfg;

    logic          w_a_we, w_a_re, w_b_we, w_b_re;
    logic [AW-1:0] w_a_waddr, w_a_raddr, w_b_waddr, w_b_raddr;
    logic [31:0]   w_a_wdata, w_a_rdata, w_b_wdata, w_b_rdata;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pair_bound           <= pfsb_pkg::PAIR_BOUND_RST;
            r_cfg.overflow_limit       <= pfsb_pkg::OVF_LIMIT_RST;
            r_cfg.partner_accept_below <= pfsb_pkg::ACCEPT_BELOW_RST;
            r_cfg.partner_refill_above <= pfsb_pkg::REFILL_ABOVE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pfsb_pkg::REG_PAIR_BOUND:   r_cfg.pair_bound <= i_cfg_data[0];
                pfsb_pkg::REG_OVF_LIMIT:    r_cfg.overflow_limit <= i_cfg_data[3:0];
                pfsb_pkg::REG_ACCEPT_BELOW: r_cfg.partner_accept_below <= i_cfg_data[4:0];
                pfsb_pkg::REG_REFILL_ABOVE: r_cfg.partner_refill_above <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // control
    pfsb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_a_we      (w_a_we),
        .o_a_waddr   (w_a_waddr),
        .o_a_wdata   (w_a_wdata),
        .o_a_re      (w_a_re),
        .o_a_raddr   (w_a_raddr),
        .i_a_rdata   (w_a_rdata),
        .o_b_we      (w_b_we),
        .o_b_waddr   (w_b_waddr),
        .o_b_wdata   (w_b_wdata),
        .o_b_re      (w_b_re),
        .o_b_raddr   (w_b_raddr),
        .i_b_rdata   (w_b_rdata)
    );

    // queue a store
    pfsb_mem #(
        .DEPTH (DEPTH)
    ) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_a_waddr),
        .i_wdata (w_a_wdata),
        .i_re    (w_a_re),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    // queue b store
    pfsb_mem #(
        .DEPTH (DEPTH)
    ) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_b_waddr),
        .i_wdata (w_b_wdata),
        .i_re    (w_b_re),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

endmodule

`default_nettype wire

// ===== test/pfsb_checker.sv =====
// scoreboard for the paired fifo spill balance unit: predicts every result beat and compares
`timescale 1ns / 1ps

module pfsb_checker
    import pfsb_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire t_in_item              i_in_data,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire t_out_item             i_out_data,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    // shadow copy of both queues
    logic [31:0] fifo_mem [2][DEPTH];
    int unsigned rd_idx [2];
    int unsigned wr_idx [2];
    int unsigned queue_fill [2];

    // shadow copy of the registers
    logic       cfg_bound;
    logic [3:0] cfg_ovf_limit;
    logic [4:0] cfg_accept_below;
    logic [3:0] cfg_refill_above;

    // result beats still owed by the block, oldest first
    t_out_item owed_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(string msg);
        $display("checker: %s", msg);
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    function automatic void fifo_push(int s, logic [31:0] v);
        fifo_mem[s][wr_idx[s]] = v;
        wr_idx[s] = (wr_idx[s] + 1) % DEPTH;
        queue_fill[s]++;
    endfunction

    function automatic logic [31:0] fifo_pop(int s);
        logic [31:0] v;
        v = fifo_mem[s][rd_idx[s]];
        rd_idx[s] = (rd_idx[s] + 1) % DEPTH;
        queue_fill[s]--;
        return v;
    endfunction

    // apply one command beat to the shadow queues and build its result
    function automatic t_out_item predict_result(t_in_item beat);
        t_out_item res;
        int        me;
        int        mate;
        res  = '0;
        me   = beat.queue_sel ? 1 : 0;
        mate = 1 - me;
        case (beat.cmd)
            CMD_ENQ: begin
                if (queue_fill[me] >= DEPTH) begin
                    res.dropped_full = 1'b1;
                end else begin
                    fifo_push(me, beat.push_value);
                    if (queue_fill[me] > cfg_ovf_limit) begin
                        res.single_overflow = 1'b1;
                        // spill the head across when the partner has room
                        if (cfg_bound) begin
                            if (queue_fill[mate] < cfg_accept_below &&
                                queue_fill[mate] < DEPTH) begin
                                fifo_push(mate, fifo_pop(me));
                            end else begin
                                res.pair_overflow = 1'b1;
                            end
                        end
                    end
                end
            end
            CMD_DEQ: begin
                if (queue_fill[me] == 0) begin
                    res.was_empty = 1'b1;
                end else begin
                    res.result_value = fifo_pop(me);
                    // refill an emptied bound queue from the partner head
                    if (queue_fill[me] == 0 && cfg_bound) begin
                        if (queue_fill[mate] > cfg_refill_above) begin
                            fifo_push(me, fifo_pop(mate));
                        end else begin
                            res.pair_empty = 1'b1;
                        end
                    end
                end
            end
            CMD_QRY: begin
                if (queue_fill[me] == 0) begin
                    res.was_empty = 1'b1;
                end else begin
                    res.result_value = fifo_mem[me][rd_idx[me]];
                end
            end
            default: ;
        endcase
        res.count_a = 5'(queue_fill[0]);
        res.count_b = 5'(queue_fill[1]);
        return res;
    endfunction

    // watch all three channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (!i_rst_n) begin
            for (int s = 0; s < 2; s++) begin
                rd_idx[s]     = 0;
                wr_idx[s]     = 0;
                queue_fill[s] = 0;
            end
            cfg_bound        = PAIR_BOUND_RST;
            cfg_ovf_limit    = OVF_LIMIT_RST;
            cfg_accept_below = ACCEPT_BELOW_RST;
            cfg_refill_above = REFILL_ABOVE_RST;
            owed_results.delete();
        end else begin
            // register write beat
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PAIR_BOUND:   cfg_bound        = i_cfg_data[0];
                    REG_OVF_LIMIT:    cfg_ovf_limit    = i_cfg_data[3:0];
                    REG_ACCEPT_BELOW: cfg_accept_below = i_cfg_data[4:0];
                    REG_REFILL_ABOVE: cfg_refill_above = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            // result beat against the oldest owed result
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result beat with nothing owed");
                end else begin
                    want = owed_results.pop_front();
                    check_field("result_value", i_out_data.result_value, want.result_value);
                    check_field("was_empty", i_out_data.was_empty, want.was_empty);
                    check_field("single_overflow", i_out_data.single_overflow,
                                want.single_overflow);
                    check_field("pair_overflow", i_out_data.pair_overflow, want.pair_overflow);
                    check_field("pair_empty", i_out_data.pair_empty, want.pair_empty);
                    check_field("dropped_full", i_out_data.dropped_full, want.dropped_full);
                    check_field("count_a", i_out_data.count_a, want.count_a);
                    check_field("count_b", i_out_data.count_b, want.count_b);
                end
            end
            // command beat
            if (i_in_valid && i_in_ready) begin
                owed_results.push_back(predict_result(i_in_data));
            end
        end
        o_pending = owed_results.size();
    end

endmodule

// ===== test/tb_paired_fifo_spill_balance_unit.sv =====
// top of the paired fifo spill balance unit testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_paired_fifo_spill_balance_unit;
    import pfsb_pkg::*;

    localparam int unsigned DEPTH = DEPTH_DEF;
    localparam int SETTLE_CYCLES  = 3;
    localparam int END_WAIT_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 120;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_data   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  cfg_ready;
    t_out_item             out_data;
    int                    fail_count;
    int                    pending;

    // pacing knobs: stall and hold settings shared with the receiver, gap settings used by send_item
    int stall_mode  = 0;
    int gap_mode    = 0;
    int burst_left  = 0;
    int hold_tokens = 0;

    paired_fifo_spill_balance_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    pfsb_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: own stall pattern plus long hold-offs on request
    initial begin : receiver
        int hold_seen;
        int hold_left;
        int tick;
        hold_seen = 0;
        hold_left = 0;
        tick      = 0;
        forever begin
            @(negedge clk);
            tick = (tick + 1) % 7;
            if (hold_tokens != hold_seen) begin
                hold_seen = hold_tokens;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(1));
                    2:       out_ready <= ($urandom_range(3) == 0);
                    default: out_ready <= (tick < 3);
                endcase
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_cmd pick_cmd(int enq_pct, int deq_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < enq_pct) return CMD_ENQ;
        if (roll < enq_pct + deq_pct) return CMD_DEQ;
        if (roll < 97) return CMD_QRY;
        return CMD_NOP;
    endfunction

    // offer one command beat; called and returns at a falling edge
    task automatic send_item(t_cmd cmd, logic sel, logic [31:0] value);
        if (gap_mode != 0 && burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        burst_left--;
        in_data  <= '{cmd: cmd, queue_sel: sel, push_value: value};
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering and wait until every owed result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write all four registers back to back
    task automatic write_config(logic bound, logic [3:0] ovf, logic [4:0] acc,
                                logic [3:0] refill);
        t_reg_idx              regs [4];
        logic [CFG_DATA_W-1:0] vals [4];
        regs = '{REG_PAIR_BOUND, REG_OVF_LIMIT, REG_ACCEPT_BELOW, REG_REFILL_ABOVE};
        vals = '{CFG_DATA_W'(bound), CFG_DATA_W'(ovf), acc, CFG_DATA_W'(refill)};
        for (int r = 0; r < 4; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[r];
            cfg_data  <= vals[r];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // one random stretch under one register setting
    task automatic run_phase(logic bound, logic [3:0] ovf, logic [4:0] acc, logic [3:0] refill,
                             int n, int enq_pct, int deq_pct, int a_pct, int smode, int gmode,
                             bit hold);
        settle();
        write_config(bound, ovf, acc, refill);
        stall_mode = smode;
        gap_mode   = gmode;
        if (hold) hold_tokens++;
        repeat (n) begin
            send_item(pick_cmd(enq_pct, deq_pct), ($urandom_range(99) < a_pct) ? 1'b0 : 1'b1,
                      pick_word());
        end
    endtask

    initial begin : stimulus
        int guard;
        int enq;

        // hold synchronous reset, then release it at a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset setting, queues independent
        stall_mode = 1;
        send_item(CMD_QRY, 1'b0, 32'h0);
        send_item(CMD_DEQ, 1'b1, 32'h0);
        send_item(CMD_NOP, 1'b1, 32'hffff_ffff);
        send_item(CMD_ENQ, 1'b0, 32'h7fff_ffff);
        send_item(CMD_ENQ, 1'b0, 32'h8000_0000);
        send_item(CMD_ENQ, 1'b1, 32'h0);
        send_item(CMD_QRY, 1'b0, 32'h0);
        send_item(CMD_DEQ, 1'b0, 32'h0);
        send_item(CMD_DEQ, 1'b0, 32'h0);
        send_item(CMD_DEQ, 1'b0, 32'h0);
        send_item(CMD_DEQ, 1'b1, 32'h0);

        // directed: bound, spill on every overflow, refill from any partner
        settle();
        write_config(1'b1, 4'd1, 5'd16, 4'd0);
        send_item(CMD_ENQ, 1'b0, 32'hffff_ffff);
        send_item(CMD_ENQ, 1'b0, 32'd5);
        send_item(CMD_ENQ, 1'b1, 32'd7);
        send_item(CMD_DEQ, 1'b0, 32'h0);
        send_item(CMD_DEQ, 1'b0, 32'h0);
        send_item(CMD_DEQ, 1'b0, 32'h0);
        send_item(CMD_QRY, 1'b1, 32'h0);

        // directed: partner accepts only when empty, so the second spill is refused
        settle();
        write_config(1'b1, 4'd1, 5'd1, 4'd15);
        send_item(CMD_ENQ, 1'b0, 32'd1);
        send_item(CMD_ENQ, 1'b0, 32'd2);
        send_item(CMD_ENQ, 1'b0, 32'd3);

        // random stretches over fixed settings, extremes included
        run_phase(1'b0, 4'd10, 5'd9, 4'd1, 200, 70, 15, 50, 1, 1, 1'b0);
        run_phase(1'b0, 4'd15, 5'd16, 4'd15, 120, 20, 70, 50, 0, 0, 1'b0);
        run_phase(1'b1, 4'd10, 5'd9, 4'd1, 200, 55, 35, 50, 2, 1, 1'b0);
        run_phase(1'b1, 4'd1, 5'd16, 4'd0, 150, 50, 40, 70, 3, 0, 1'b1);
        run_phase(1'b1, 4'd15, 5'd1, 4'd15, 150, 60, 30, 50, 1, 1, 1'b0);
        run_phase(1'b1, 4'd1, 5'd1, 4'd0, 120, 45, 45, 30, 0, 1, 1'b0);
        run_phase(1'b1, 4'd15, 5'd16, 4'd0, 150, 65, 25, 80, 2, 0, 1'b0);

        // random stretches over random settings
        repeat (4) begin
            enq = $urandom_range(35, 65);
            run_phase(1'b1, 4'($urandom_range(1, 15)), 5'($urandom_range(1, 16)),
                      4'($urandom_range(0, 15)), 150, enq, 90 - enq, $urandom_range(20, 80),
                      $urandom_range(3), $urandom_range(1), 1'b0);
        end

        // drain, then verdict
        in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < END_WAIT_LIMIT) begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending != 0) $display("tb: %0d result beats never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pfsb_pkg.sv
sv/pfsb_mem.sv
sv/pfsb_ctrl.sv
sv/paired_fifo_spill_balance_unit.sv
test/pfsb_checker.sv
test/tb_paired_fifo_spill_balance_unit.sv
